// File: rtl/core/xxtea_pkg.sv
// Shared types, constants and round functions for the XXTEA cell chain.
package xxtea_pkg;

    localparam int ROUND_COUNT = 19;
    localparam int NUM_CELLS   = ROUND_COUNT * 4;
    localparam int AGE_W       = $clog2(NUM_CELLS + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    typedef logic [31:0]          word_t;
    typedef word_t [3:0]          block_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [AGE_W-1:0]     age_t;

    localparam cfg_idx_t REG_KEY_WORD0 = 3'd0;
    localparam cfg_idx_t REG_KEY_WORD1 = 3'd1;
    localparam cfg_idx_t REG_KEY_WORD2 = 3'd2;
    localparam cfg_idx_t REG_KEY_WORD3 = 3'd3;

    localparam block_t KEY_RESET = {32'hCCDD_EEFF, 32'h8899_AABB, 32'h4455_6677, 32'h0011_2233};

    // Block in flight between cells
    typedef struct packed {
        logic   decrypt;
        block_t words;
    } cell_data_t;

    // Fixed per-cell settings: running sum for either direction, word position
    typedef struct packed {
        word_t      sum_enc;
        word_t      sum_dec;
        logic [1:0] pos;
    } cell_const_t;

    // Settings of cell k: round k/4, word k%4 (encrypt) or 3-k%4 (decrypt)
    function automatic cell_const_t cell_const(int k);
        cell_const_t c;
        logic [31:0] r;
        r         = 32'(k >> 2);
        c.sum_enc = DELTA * (r + 32'd1);
        c.sum_dec = DELTA * (32'(ROUND_COUNT) - r);
        c.pos     = 2'(k);
        return c;
    endfunction

    function automatic word_t xx_mix(word_t z, word_t y, word_t sum, logic [1:0] p,
                                     block_t key);
        word_t      a;
        word_t      b;
        logic [1:0] e;
        e = sum[3:2];
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key[p ^ e] ^ z);
        return a ^ b;
    endfunction

endpackage

// File: rtl/core/xxtea_block_cipher_128_core.sv
// XXTEA 128-bit block cipher core: key registers and a chain of round cells.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  request  | start & !busy         | action, in_word0..in_word3
//  result   | done (one-cycle strobe)| out_word0..out_word3
//  config   | cfg_valid & cfg_ready | cfg_index (0..3 key words), cfg_data
//
//  One request per cycle. Each request passes 76 cells (19 rounds of four word
//  updates, one update per cell), and each cell registers its word update, so
//  done is raised once the request has passed the last cell.
//  Latency is set by the length of the cell chain; throughput by one cell.
//  Reset clears the valid bits of the chain and loads the default key.
//  busy stays low and the result side cannot stall: the chain never stops.
//  Key writes are taken at any time but must only happen with no request in
//  flight.
module xxtea_block_cipher_128_core import xxtea_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // request
    input  logic     start,
    output logic     busy,
    input  logic     action,
    input  word_t    in_word0,
    input  word_t    in_word1,
    input  word_t    in_word2,
    input  word_t    in_word3,
    // result
    output logic     done,
    output word_t    out_word0,
    output word_t    out_word1,
    output word_t    out_word2,
    output word_t    out_word3,
    // key configuration
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_idx_t cfg_index,
    input  word_t    cfg_data
);

    block_t     key_reg;
    block_t     key_next;

    logic       valid_chain [NUM_CELLS+1];
    cell_data_t data_chain  [NUM_CELLS+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- key regs
    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_WORD0: key_next[0] = cfg_data;
                REG_KEY_WORD1: key_next[1] = cfg_data;
                REG_KEY_WORD2: key_next[2] = cfg_data;
                REG_KEY_WORD3: key_next[3] = cfg_data;
                default:       key_next    = key_reg;  // unused index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // ---------------------------------------------------------------- chain
    assign valid_chain[0]         = start && !busy;
    assign data_chain[0].decrypt  = action;
    assign data_chain[0].words    = {in_word3, in_word2, in_word1, in_word0};

    // cell k updates word k%4 (encrypt) or 3-k%4 (decrypt) of round k/4;
    // sums are fixed per cell
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        localparam cell_const_t CONSTS = cell_const(k);

        xxtea_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .consts    (CONSTS),
            .key       (key_reg),
            .in_valid  (valid_chain[k]),
            .in_data   (data_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_data  (data_chain[k+1])
        );
    end

    // ---------------------------------------------------------------- result
    assign done      = valid_chain[NUM_CELLS];
    assign out_word0 = data_chain[NUM_CELLS].words[0];
    assign out_word1 = data_chain[NUM_CELLS].words[1];
    assign out_word2 = data_chain[NUM_CELLS].words[2];
    assign out_word3 = data_chain[NUM_CELLS].words[3];

endmodule

// File: rtl/core/xxtea_cell.sv
// One XXTEA word update: a single cell of the round chain.
module xxtea_cell import xxtea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_const_t consts,
    input  block_t      key,
    input  logic        in_valid,
    input  cell_data_t  in_data,
    output logic        out_valid,
    output cell_data_t  out_data
);

    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;
    logic [1:0] p;
    word_t      sum;
    word_t      z;
    word_t      y;
    word_t      m;

    // decrypt walks the words in reverse order
    always_comb
    begin
        p         = in_data.decrypt ? ~consts.pos : consts.pos;
        sum       = in_data.decrypt ? consts.sum_dec : consts.sum_enc;
        z         = in_data.words[p - 2'd1];
        y         = in_data.words[p + 2'd1];
        m         = xx_mix(z, y, sum, p, key);
        data_next = in_data;
        if (in_data.decrypt)
        begin
            data_next.words[p] = in_data.words[p] - m;
        end
        else
        begin
            data_next.words[p] = in_data.words[p] + m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/xxtea_checker.sv
// Port-level checks for the XXTEA core, bound to the top level.
module xxtea_checker import xxtea_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    age_t age_reg;
    age_t age_next;
    logic settled;

    // cycles since reset, saturating once the chain has filled
    assign settled  = (age_reg == age_t'(NUM_CELLS));
    assign age_next = settled ? age_reg : age_reg + age_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else
        begin
            age_reg <= age_next;
        end
    end

    // a result only for a request that has passed the whole chain
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        settled && done |-> $past(start && !busy, NUM_CELLS))
        else $error("result without matching request");

    // every request yields its result once it has passed the whole chain
    a_request_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        settled && $past(start && !busy, NUM_CELLS) |-> done)
        else $error("request lost in the chain");

    // no result while held in reset
    a_quiet_in_reset: assert property (@(posedge clk)
        !rst_n |-> !done)
        else $error("result strobe during reset");

endmodule

bind xxtea_block_cipher_128_core xxtea_checker u_xxtea_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
